### rtl/core/tst_pkg.sv
// Shared types, codes and defaults for the thread state table.
package tst_pkg;

  // Default configuration
  localparam int THREADS_DEF = 16;
  localparam int CPUS_DEF    = 4;

  // Operation codes
  localparam logic [3:0] OP_INIT        = 4'd0;
  localparam logic [3:0] OP_INIT_IDLE   = 4'd1;
  localparam logic [3:0] OP_ENQUEUE     = 4'd2;
  localparam logic [3:0] OP_DEQUEUE     = 4'd3;
  localparam logic [3:0] OP_READY       = 4'd4;
  localparam logic [3:0] OP_RUNNING     = 4'd5;
  localparam logic [3:0] OP_BLOCKED     = 4'd6;
  localparam logic [3:0] OP_EXITING     = 4'd7;
  localparam logic [3:0] OP_ZOMBIE      = 4'd8;
  localparam logic [3:0] OP_DETACH      = 4'd9;
  localparam logic [3:0] OP_CANCEL      = 4'd10;
  localparam logic [3:0] OP_CANCEL_EN   = 4'd11;
  localparam logic [3:0] OP_QUERY       = 4'd12;

  // Lifecycle state codes
  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_RUNNING = 3'd2;
  localparam logic [2:0] ST_BLOCKED = 3'd3;
  localparam logic [2:0] ST_EXITING = 3'd4;
  localparam logic [2:0] ST_ZOMBIE  = 3'd5;
  localparam logic [2:0] ST_IDLE    = 3'd6;

  // Flag bit positions
  localparam int FL_IDLE        = 0;
  localparam int FL_DETACHED    = 1;
  localparam int FL_QUEUED      = 2;
  localparam int FL_CANCEL_PEND = 3;
  localparam int FL_CANCEL_DIS  = 4;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_EXEC
  } fsm_e;

  // Request payload
  typedef struct packed {
    logic [3:0]  op;
    logic [3:0]  thread_index;
    logic [1:0]  cpu_index;
    logic [3:0]  wait_reason;
    logic [31:0] exit_value;
    logic        want_detached;
    logic        cancel_enable;
    logic [31:0] stack_low;
    logic [31:0] stack_high;
    logic        entry_given;
  } req_t;

  // Response payload
  typedef struct packed {
    logic        ok;
    logic [3:0]  popped_thread;
    logic [2:0]  run_state;
    logic [4:0]  flag_bits;
    logic [4:0]  queue_depth;
    logic [3:0]  reason_now;
    logic [31:0] exit_now;
    logic [1:0]  cpu_now;
    logic        cpu_known;
  } rsp_t;

  // One thread record as stored in the table memory
  typedef struct packed {
    logic [2:0]  run_state;
    logic [4:0]  flags;
    logic [3:0]  reason;
    logic [31:0] exit_word;
    logic [1:0]  cpu;
    logic        cpu_known;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

### rtl/core/tst_if.sv
// Request and response channel interfaces of the thread state table.
interface tst_req_if
  import tst_pkg::*;
;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tst_rsp_if
  import tst_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/tst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds data while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/thread_state_table_with_ready_fifo.sv
// Top level of the thread state table with its FIFO ready queue.
//
// Usage:
//   req_i carries one operation per transaction (init, enqueue, dequeue,
//   state marks, detach, cancel, query). rsp_o returns exactly one
//   transaction per request: an ok bit, the touched thread id, its record
//   and the ready queue depth after the operation.
//   Thread records live in a table RAM, the ready queue ids in a FIFO RAM;
//   both have a registered read.
//   Sequence: a request is taken and its table read issued; when the read
//   returns, the record is modified, written back and the response
//   registered. A dequeue that finds the queue non-empty first reads the
//   FIFO head, then the table. A new request is taken only after the last
//   one is written back, as the table RAM is read and then written.
//   Reset clears the queue pointers and a per-thread valid bit, so every
//   record reads as a new thread with no flags right after reset; no
//   clearing pass is needed.
//   A new request is taken while a response waits; if the receiver stalls,
//   that response holds and the next operation waits before write-back.
module thread_state_table_with_ready_fifo
  import tst_pkg::*;
#(
  parameter int THREADS = THREADS_DEF,
  parameter int CPUS    = CPUS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tst_req_if.sink      req_i,
  tst_rsp_if.source    rsp_o
);

  localparam int AW  = $clog2(THREADS);
  localparam int CNW = $clog2(THREADS + 1);

  fsm_e state_q, state_d;

  // Captured request
  logic [3:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [3:0]    thread4_q;
  logic          in_range_q;
  logic [1:0]    cpu_q;
  logic [3:0]    reason_q;
  logic [31:0]   exit_q;
  logic          det_q;
  logic          cen_q;
  logic          init_ok_q;

  // Queue pointers and occupancy
  logic [AW-1:0]  head_q, tail_q;
  logic [CNW-1:0] count_q, count_d;
  logic [THREADS-1:0] rec_valid_q;

  // Response register
  logic rsp_valid_q;
  rsp_t rsp_q, rsp_d;

  // Sequencer outputs
  logic req_ready;
  logic tbl_re;
  logic fifo_re;
  logic exec_fire;
  logic accept;

  // Memory ports
  logic [AW-1:0] tbl_raddr;
  logic [REC_W-1:0] tbl_rdata;
  logic [AW-1:0] fifo_rdata;

  // Execute datapath
  rec_t cur, nxt;
  logic ok, push, pop, report, is_idle, is_term;
  logic [3:0] tid;
  logic [1:0] cpu_mod;
  logic in_range;

  assign accept = req_i.valid && req_ready;
  assign req_i.ready = req_ready;

  // Reduce cpu index modulo CPUS (value is at most 3)
  always_comb begin
    cpu_mod = req_i.payload.cpu_index;
    if (CPUS == 1) begin
      cpu_mod = '0;
    end else begin
      if (int'(cpu_mod) >= CPUS) cpu_mod = cpu_mod - 2'(CPUS);
      if (int'(cpu_mod) >= CPUS) cpu_mod = cpu_mod - 2'(CPUS);
    end
  end

  assign in_range = 32'(req_i.payload.thread_index) < 32'(THREADS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.payload.op == OP_DEQUEUE && count_q != '0) state_d = S_POP;
          else state_d = S_EXEC;
        end
      end
      S_POP:  state_d = S_EXEC;
      S_EXEC: if (exec_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_ready = 1'b0;
    tbl_re    = 1'b0;
    fifo_re   = 1'b0;
    exec_fire = 1'b0;
    tbl_raddr = AW'(req_i.payload.thread_index);
    unique case (state_q)
      S_IDLE: begin
        req_ready = 1'b1;
        tbl_re    = accept;
        fifo_re   = accept && req_i.payload.op == OP_DEQUEUE;
      end
      S_POP: begin
        tbl_re    = 1'b1;
        tbl_raddr = fifo_rdata;
      end
      S_EXEC: exec_fire = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  // Thread record table
  tst_ram #(
    .WIDTH (REC_W),
    .DEPTH (THREADS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && ok),
    .waddr_i (addr_q),
    .wdata_i (nxt),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Ready queue slots
  tst_ram #(
    .WIDTH (AW),
    .DEPTH (THREADS)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && push),
    .waddr_i (tail_q),
    .wdata_i (addr_q),
    .re_i    (fifo_re),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  // Modify the record for the captured operation
  always_comb begin
    cur     = rec_valid_q[addr_q] ? rec_t'(tbl_rdata) : '0;
    nxt     = cur;
    ok      = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    report  = 1'b1;
    tid     = thread4_q;
    is_idle = cur.flags[FL_IDLE];
    is_term = cur.run_state == ST_EXITING || cur.run_state == ST_ZOMBIE;

    if (op_q == OP_DEQUEUE) begin
      tid = 4'(addr_q);
      if (count_q == '0) begin
        report = 1'b0;
        tid    = '0;
      end else begin
        nxt.flags[FL_QUEUED] = 1'b0;
        ok  = 1'b1;
        pop = 1'b1;
      end
    end else if (!in_range_q) begin
      report = 1'b0;
    end else begin
      unique case (op_q)
        OP_INIT: begin
          if (init_ok_q) begin
            nxt = '0;
            nxt.flags[FL_DETACHED] = det_q;
            ok = 1'b1;
          end
        end
        OP_INIT_IDLE: begin
          nxt = '0;
          nxt.run_state     = ST_IDLE;
          nxt.flags[FL_IDLE] = 1'b1;
          nxt.cpu           = cpu_q;
          nxt.cpu_known     = 1'b1;
          ok = 1'b1;
        end
        OP_ENQUEUE: begin
          if (!is_idle && !is_term && !cur.flags[FL_QUEUED] &&
              count_q != CNW'(THREADS)) begin
            nxt.flags[FL_QUEUED] = 1'b1;
            nxt.reason    = '0;
            nxt.run_state = ST_READY;
            push = 1'b1;
            ok   = 1'b1;
          end
        end
        OP_READY, OP_RUNNING: begin
          nxt.cpu       = cpu_q;
          nxt.cpu_known = 1'b1;
          nxt.flags[FL_QUEUED] = 1'b0;
          nxt.reason    = '0;
          if (!is_idle && !is_term) begin
            nxt.run_state = (op_q == OP_READY) ? ST_READY : ST_RUNNING;
          end
          ok = 1'b1;
        end
        OP_BLOCKED: begin
          nxt.flags[FL_QUEUED] = 1'b0;
          nxt.reason = reason_q;
          if (!is_idle && !is_term) nxt.run_state = ST_BLOCKED;
          ok = 1'b1;
        end
        OP_EXITING, OP_ZOMBIE: begin
          if (!is_idle) begin
            nxt.flags[FL_QUEUED] = 1'b0;
            nxt.reason = '0;
            if (op_q == OP_EXITING) begin
              nxt.exit_word = exit_q;
              nxt.run_state = ST_EXITING;
            end else begin
              nxt.run_state = ST_ZOMBIE;
            end
            ok = 1'b1;
          end
        end
        OP_DETACH: begin
          if (!is_idle && cur.run_state != ST_ZOMBIE && !cur.flags[FL_DETACHED]) begin
            nxt.flags[FL_DETACHED] = 1'b1;
            ok = 1'b1;
          end
        end
        OP_CANCEL: begin
          if (!is_idle && !is_term) begin
            nxt.flags[FL_CANCEL_PEND] = 1'b1;
            ok = 1'b1;
          end
        end
        OP_CANCEL_EN: begin
          nxt.flags[FL_CANCEL_DIS] = !cen_q;
          ok = 1'b1;
        end
        OP_QUERY: ok = 1'b1;
        default: ;
      endcase
    end
  end

  // Queue occupancy after the step
  always_comb begin
    count_d = count_q;
    if (push) count_d = count_q + 1'b1;
    else if (pop) count_d = count_q - 1'b1;
  end

  // Build the response transaction
  always_comb begin
    rsp_d.ok            = ok;
    rsp_d.popped_thread = tid;
    rsp_d.queue_depth   = 5'(count_d);
    rsp_d.run_state     = report ? nxt.run_state : '0;
    rsp_d.flag_bits     = report ? nxt.flags : '0;
    rsp_d.reason_now    = report ? nxt.reason : '0;
    rsp_d.exit_now      = report ? nxt.exit_word : '0;
    rsp_d.cpu_now       = report ? nxt.cpu : '0;
    rsp_d.cpu_known     = report ? nxt.cpu_known : 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      rec_valid_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        rsp_valid_q <= 1'b1;
        count_q     <= count_d;
        if (ok) rec_valid_q[addr_q] <= 1'b1;
        if (push) tail_q <= (tail_q == AW'(THREADS - 1)) ? '0 : tail_q + 1'b1;
        if (pop)  head_q <= (head_q == AW'(THREADS - 1)) ? '0 : head_q + 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Capture the request, then the popped id for a dequeue
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= req_i.payload.op;
      addr_q     <= AW'(req_i.payload.thread_index);
      thread4_q  <= req_i.payload.thread_index;
      in_range_q <= in_range;
      cpu_q      <= cpu_mod;
      reason_q   <= req_i.payload.wait_reason;
      exit_q     <= req_i.payload.exit_value;
      det_q      <= req_i.payload.want_detached;
      cen_q      <= req_i.payload.cancel_enable;
      init_ok_q  <= req_i.payload.entry_given &&
                    (req_i.payload.stack_high > req_i.payload.stack_low);
    end else if (state_q == S_POP) begin
      addr_q <= fifo_rdata;
    end
    if (exec_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

### rtl/core/tst_checker.sv
// Port-level checks for the thread state table, bound to the top level.
module tst_checker
  import tst_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_i
);

  // One operation in flight: no request is taken right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while an operation is in flight");

  // A stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled response changed");

  // No cpu value without an assignment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_i.cpu_known |-> rsp_i.cpu_now == '0)
    else $error("cpu reported without assignment");

  // Idle flag and idle state go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_i.flag_bits[FL_IDLE] == (rsp_i.run_state == ST_IDLE))
    else $error("idle flag and idle state disagree");

endmodule

bind thread_state_table_with_ready_fifo tst_checker u_tst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);

### tb/tst_sched_checker.sv
// Scoreboard for the thread state table: predicts every response and checks it.
`timescale 1ns / 1ps

module tst_sched_checker
  import tst_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_payload_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_payload_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   request_count_o,
  output int   refusal_count_o,
  output int   peak_depth_o
);

  localparam int NTH         = THREADS_DEF;
  localparam int MAX_REPORTS = 40;

  // Shadow copy of the thread table and the ready queue
  logic [2:0]  th_state     [NTH];
  logic [4:0]  th_flags     [NTH];
  logic [3:0]  th_reason    [NTH];
  logic [31:0] th_exit      [NTH];
  logic [1:0]  th_cpu       [NTH];
  logic        th_cpu_known [NTH];
  int          runq_ids     [NTH];
  int          runq_head;
  int          runq_tail;
  int          runq_count;

  // Responses still owed by the block, oldest first
  rsp_t expected_status_q[$];

  function automatic logic thread_live(int t);
    return !th_flags[t][FL_IDLE] && th_state[t] != ST_EXITING && th_state[t] != ST_ZOMBIE;
  endfunction

  // Shared part of ready, running and blocked: the state moves only for live threads
  function automatic void mark_live(int t, logic [2:0] next_state, logic [3:0] reason);
    logic live;
    live = thread_live(t);
    th_flags[t][FL_QUEUED] = 1'b0;
    th_reason[t] = reason;
    if (live) th_state[t] = next_state;
  endfunction

  // Apply one operation to the shadow table and build the response it should give
  function automatic rsp_t apply_sched_op(req_t r);
    rsp_t o;
    int   t;
    logic report;
    o = '0;
    t = int'(r.thread_index);
    report = 1'b1;
    if (r.op == OP_DEQUEUE) begin
      if (runq_count == 0) begin
        report = 1'b0;
        t = 0;
      end else begin
        t = runq_ids[runq_head];
        runq_head = (runq_head + 1) % NTH;
        runq_count--;
        th_flags[t][FL_QUEUED] = 1'b0;
        o.ok = 1'b1;
      end
    end else if (t >= NTH) begin
      report = 1'b0;
    end else begin
      case (r.op)
        OP_INIT: begin
          if (r.entry_given && r.stack_high > r.stack_low) begin
            th_state[t]     = ST_NEW;
            th_reason[t]    = '0;
            th_flags[t]     = '0;
            th_flags[t][FL_DETACHED] = r.want_detached;
            th_exit[t]      = '0;
            th_cpu[t]       = '0;
            th_cpu_known[t] = 1'b0;
            o.ok = 1'b1;
          end
        end
        OP_INIT_IDLE: begin
          th_state[t]     = ST_IDLE;
          th_reason[t]    = '0;
          th_flags[t]     = '0;
          th_flags[t][FL_IDLE] = 1'b1;
          th_exit[t]      = '0;
          th_cpu[t]       = 2'(r.cpu_index % CPUS_DEF);
          th_cpu_known[t] = 1'b1;
          o.ok = 1'b1;
        end
        OP_ENQUEUE: begin
          if (thread_live(t) && !th_flags[t][FL_QUEUED] && runq_count < NTH) begin
            runq_ids[runq_tail] = t;
            runq_tail = (runq_tail + 1) % NTH;
            runq_count++;
            th_flags[t][FL_QUEUED] = 1'b1;
            th_reason[t] = '0;
            th_state[t]  = ST_READY;
            o.ok = 1'b1;
          end
        end
        OP_READY, OP_RUNNING: begin
          th_cpu[t]       = 2'(r.cpu_index % CPUS_DEF);
          th_cpu_known[t] = 1'b1;
          mark_live(t, (r.op == OP_READY) ? ST_READY : ST_RUNNING, '0);
          o.ok = 1'b1;
        end
        OP_BLOCKED: begin
          mark_live(t, ST_BLOCKED, r.wait_reason);
          o.ok = 1'b1;
        end
        OP_EXITING, OP_ZOMBIE: begin
          if (!th_flags[t][FL_IDLE]) begin
            th_flags[t][FL_QUEUED] = 1'b0;
            th_reason[t] = '0;
            if (r.op == OP_EXITING) begin
              th_exit[t]  = r.exit_value;
              th_state[t] = ST_EXITING;
            end else begin
              th_state[t] = ST_ZOMBIE;
            end
            o.ok = 1'b1;
          end
        end
        OP_DETACH: begin
          if (!th_flags[t][FL_IDLE] && th_state[t] != ST_ZOMBIE &&
              !th_flags[t][FL_DETACHED]) begin
            th_flags[t][FL_DETACHED] = 1'b1;
            o.ok = 1'b1;
          end
        end
        OP_CANCEL: begin
          if (thread_live(t)) begin
            th_flags[t][FL_CANCEL_PEND] = 1'b1;
            o.ok = 1'b1;
          end
        end
        OP_CANCEL_EN: begin
          th_flags[t][FL_CANCEL_DIS] = !r.cancel_enable;
          o.ok = 1'b1;
        end
        OP_QUERY: begin
          o.ok = 1'b1;
        end
        default: begin
          // unused codes are refused but still report the thread
        end
      endcase
    end
    o.popped_thread = 4'(t);
    o.queue_depth   = 5'(runq_count);
    if (report) begin
      o.run_state  = th_state[t];
      o.flag_bits  = th_flags[t];
      o.reason_now = th_reason[t];
      o.exit_now   = th_exit[t];
      o.cpu_now    = th_cpu[t];
      o.cpu_known  = th_cpu_known[t];
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count_o++;
      if (mismatch_count_o <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  // Check each response transaction, then predict each request transaction
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NTH; i++) begin
        th_state[i]     = ST_NEW;
        th_flags[i]     = '0;
        th_reason[i]    = '0;
        th_exit[i]      = '0;
        th_cpu[i]       = '0;
        th_cpu_known[i] = 1'b0;
        runq_ids[i]     = 0;
      end
      runq_head  = 0;
      runq_tail  = 0;
      runq_count = 0;
      expected_status_q.delete();
      pending_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_payload_i;
        if (expected_status_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MAX_REPORTS)
            $display("%0t: unexpected response, expected none, actual 0x%0h", $time, got);
        end else begin
          want = expected_status_q.pop_front();
          check_field("ok",            32'(want.ok),            32'(got.ok));
          check_field("popped_thread", 32'(want.popped_thread), 32'(got.popped_thread));
          check_field("run_state",     32'(want.run_state),     32'(got.run_state));
          check_field("flag_bits",     32'(want.flag_bits),     32'(got.flag_bits));
          check_field("queue_depth",   32'(want.queue_depth),   32'(got.queue_depth));
          check_field("reason_now",    32'(want.reason_now),    32'(got.reason_now));
          check_field("exit_now",      want.exit_now,           got.exit_now);
          check_field("cpu_now",       32'(want.cpu_now),       32'(got.cpu_now));
          check_field("cpu_known",     32'(want.cpu_known),     32'(got.cpu_known));
        end
      end
      if (req_valid_i && req_ready_i) begin
        want = apply_sched_op(req_payload_i);
        expected_status_q.push_back(want);
        request_count_o++;
        if (!want.ok) refusal_count_o++;
        if (int'(want.queue_depth) > peak_depth_o) peak_depth_o = int'(want.queue_depth);
      end
      pending_o = expected_status_q.size();
    end
  end

endmodule

### tb/tb_thread_state_table_with_ready_fifo.sv
// Testbench top: clock, reset, request stimulus, response stalls and the verdict.
`timescale 1ns / 1ps

module tb_thread_state_table_with_ready_fifo;
  import tst_pkg::*;

  localparam logic [3:0] OP_UNUSED_LO     = 4'd13;
  localparam int         RANDOM_PER_PHASE = 300;
  localparam int         HOLD_CYCLES      = 300;

  // Operation mixes: one builds up the ready queue, the other drains it
  localparam logic [3:0] FILL_MIX [20] = '{
    OP_ENQUEUE, OP_ENQUEUE, OP_ENQUEUE, OP_ENQUEUE, OP_ENQUEUE, OP_ENQUEUE,
    OP_READY, OP_READY, OP_RUNNING, OP_RUNNING, OP_BLOCKED, OP_BLOCKED,
    OP_DEQUEUE, OP_INIT, OP_INIT, OP_QUERY, OP_DETACH, OP_CANCEL,
    OP_CANCEL_EN, OP_EXITING
  };
  localparam logic [3:0] DRAIN_MIX [20] = '{
    OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE, OP_DEQUEUE,
    OP_ENQUEUE, OP_ENQUEUE, OP_READY, OP_RUNNING, OP_BLOCKED, OP_EXITING,
    OP_EXITING, OP_INIT, OP_INIT, OP_DETACH, OP_CANCEL, OP_CANCEL_EN,
    OP_QUERY, OP_QUERY
  };

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   stall_pct;
  bit   hold_req;
  bit   hold_rsp;
  int   mismatches;
  int   pending;
  int   requests;
  int   refusals;
  int   peak_depth;

  tst_req_if req_if ();
  tst_rsp_if rsp_if ();

  thread_state_table_with_ready_fifo i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tst_sched_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_payload_i    (req_if.payload),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_payload_i    (rsp_if.payload),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .request_count_o  (requests),
    .refusal_count_o  (refusals),
    .peak_depth_o     (peak_depth)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Drive response ready at the falling edge, random stalls unless held off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  // Hold off responses for a long stretch once asked, so the block backs up
  initial begin
    wait (hold_req);
    hold_rsp = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    hold_rsp = 1'b0;
  end

  function automatic req_t plain_request(logic [3:0] op, logic [3:0] thread);
    req_t r;
    r = '0;
    r.op           = op;
    r.thread_index = thread;
    r.stack_low    = 32'h0000_1000;
    r.stack_high   = 32'h0000_8000;
    r.entry_given  = 1'b1;
    return r;
  endfunction

  function automatic req_t random_request(bit fill_mode);
    req_t        r;
    int          pick;
    logic [31:0] swap;
    pick = $urandom_range(99);
    if (pick < 3)       r.op = OP_UNUSED_LO + 4'($urandom_range(2));
    else if (pick < 5)  r.op = OP_INIT_IDLE;
    else if (pick < 7)  r.op = OP_ZOMBIE;
    else if (fill_mode) r.op = FILL_MIX[$urandom_range(19)];
    else                r.op = DRAIN_MIX[$urandom_range(19)];
    r.thread_index  = 4'($urandom_range(15));
    r.cpu_index     = 2'($urandom_range(3));
    r.wait_reason   = 4'($urandom_range(15));
    r.exit_value    = $urandom;
    r.want_detached = 1'($urandom_range(1));
    r.cancel_enable = 1'($urandom_range(1));
    r.stack_low     = $urandom;
    r.stack_high    = $urandom;
    r.entry_given   = ($urandom_range(99) < 85);
    // Order most init stacks so that creation usually succeeds
    if (r.op == OP_INIT && $urandom_range(3) != 0 && r.stack_high < r.stack_low) begin
      swap         = r.stack_low;
      r.stack_low  = r.stack_high;
      r.stack_high = swap;
    end
    return r;
  endfunction

  // Offer one request after a random gap and hold it until the transaction
  task automatic offer_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.payload = r;
    req_if.valid   = 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stimulus
  initial begin
    req_t d;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty dequeue, init refusals and a detached init
    offer_request(plain_request(OP_DEQUEUE, 4'd9));
    d = plain_request(OP_INIT, 4'd0);
    d.entry_given = 1'b0;
    offer_request(d);
    d = plain_request(OP_INIT, 4'd0);
    d.stack_low  = 32'hffff_ffff;
    d.stack_high = 32'h0000_0000;
    offer_request(d);
    d = plain_request(OP_INIT, 4'd0);
    d.stack_low  = 32'h5555_aaaa;
    d.stack_high = 32'h5555_aaaa;
    offer_request(d);
    d = plain_request(OP_INIT, 4'd15);
    d.want_detached = 1'b1;
    d.stack_low     = 32'h0000_0000;
    d.stack_high    = 32'hffff_ffff;
    offer_request(d);

    // Directed: an idle thread refuses most operations
    d = plain_request(OP_INIT_IDLE, 4'd2);
    d.cpu_index = 2'd3;
    offer_request(d);
    offer_request(plain_request(OP_ENQUEUE, 4'd2));
    d = plain_request(OP_RUNNING, 4'd2);
    d.cpu_index = 2'd1;
    offer_request(d);
    offer_request(plain_request(OP_EXITING, 4'd2));
    offer_request(plain_request(OP_DETACH, 4'd2));
    offer_request(plain_request(OP_CANCEL, 4'd2));

    // Directed: queue twice, leave a stale entry behind, pop it
    offer_request(plain_request(OP_ENQUEUE, 4'd15));
    offer_request(plain_request(OP_ENQUEUE, 4'd15));
    offer_request(plain_request(OP_ENQUEUE, 4'd1));
    d = plain_request(OP_BLOCKED, 4'd15);
    d.wait_reason = 4'd15;
    offer_request(d);
    offer_request(plain_request(OP_ENQUEUE, 4'd15));
    offer_request(plain_request(OP_DEQUEUE, 4'd0));

    // Directed: termination, detach and cancel guards
    d = plain_request(OP_RUNNING, 4'd0);
    d.cpu_index = 2'd3;
    offer_request(d);
    d = plain_request(OP_EXITING, 4'd0);
    d.exit_value = 32'hffff_ffff;
    offer_request(d);
    offer_request(plain_request(OP_CANCEL, 4'd0));
    offer_request(plain_request(OP_ZOMBIE, 4'd1));
    offer_request(plain_request(OP_DETACH, 4'd1));
    offer_request(plain_request(OP_DETACH, 4'd15));
    offer_request(plain_request(OP_CANCEL, 4'd3));
    offer_request(plain_request(OP_CANCEL_EN, 4'd3));
    offer_request(plain_request(OP_QUERY, 4'd3));
    offer_request(plain_request(4'(OP_UNUSED_LO + 4'd2), 4'd4));

    // Random: four idling patterns, alternating fill and drain stretches
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 77 : (phase == 3) ? 9 : 0;
      stall_pct     = (phase == 2) ? 77 : (phase == 3) ? 9 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 0 && n == 100) hold_req = 1'b1;
        offer_request(random_request((n % 150) < 100));
      end
    end

    // Drain and give the verdict
    req_if.valid = 1'b0;
    stall_pct    = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("Ran %0d operations (%0d refused) under four idling patterns and a %0d-cycle",
             requests, refusals, HOLD_CYCLES);
    $display("response hold-off; the ready queue reached a depth of %0d.", peak_depth);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
